FILE: design/wmfe_pkg.sv
// ----------------------------------------------------------------------------
// Windowed motion-feature extractor package
// Shared sizes, feature and mode codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wmfe_pkg;

  // Ring geometry.
  localparam int unsigned WINDOW   = 64;
  localparam int unsigned PTR_W    = $clog2(WINDOW);
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);

  // Sample fields and their place in one stored entry.
  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned AXIS_IDX_W = 3;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned AMAG_LO    = NUM_AXES * AXIS_W;
  localparam int unsigned GMAG_LO    = AMAG_LO + MAG_W;
  localparam int unsigned TIME_LO    = GMAG_LO + MAG_W;
  localparam int unsigned ENTRY_W    = TIME_LO + TIME_W;

  // Result fields.
  localparam int unsigned VAL_W  = 48;
  localparam int unsigned FID_W  = 5;
  localparam int unsigned MODE_W = 2;

  // Accumulator and arithmetic widths.
  localparam int unsigned SUM_W      = AXIS_W + CNT_W;
  localparam int unsigned SQ_W       = 2 * AXIS_W - 1 + CNT_W;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned MEAN_DVD_W = SUM_W + FRAC_W;
  localparam int unsigned NSQ_W      = CNT_W + SQ_W;
  localparam int unsigned S2_W       = 2 * SUM_W;
  localparam int unsigned DEV_D_W    = (NSQ_W > S2_W) ? NSQ_W : S2_W;
  localparam int unsigned DEV_SHIFT  = 16;
  localparam int unsigned DEV_DVD_W  = DEV_D_W + DEV_SHIFT;
  localparam int unsigned NN_W       = 2 * CNT_W;
  localparam int unsigned JERK_SCALE = 256000;
  localparam int unsigned JSCALE_W   = 18;
  localparam int unsigned JNUM_W     = MAG_W + JSCALE_W;
  localparam int unsigned JSUM_W     = JNUM_W + CNT_W;
  localparam int unsigned DVD_A_W    = (DEV_DVD_W > JSUM_W) ? DEV_DVD_W : JSUM_W;
  localparam int unsigned DVD_B_W    = (MEAN_DVD_W > JNUM_W) ? MEAN_DVD_W : JNUM_W;
  localparam int unsigned DVD_W      = (DVD_A_W > DVD_B_W) ? DVD_A_W : DVD_B_W;
  localparam int unsigned DVS_W      = TIME_W;
  localparam int unsigned IT_W       = $clog2(DVD_W + 1);
  localparam int unsigned ROOT_W     = (DEV_DVD_W + 1) / 2;
  localparam int unsigned SQI_W      = 2 * ROOT_W;
  localparam int unsigned RIT_W      = $clog2(ROOT_W + 1);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SNAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Configuration register index.
  localparam logic REG_ENABLE = 1'b0;

  // Feature codes in emission order.
  localparam logic [FID_W-1:0] FID_AVAIL     = 5'd0;
  localparam logic [FID_W-1:0] FID_COUNT     = 5'd1;
  localparam logic [FID_W-1:0] FID_START     = 5'd2;
  localparam logic [FID_W-1:0] FID_END       = 5'd3;
  localparam logic [FID_W-1:0] FID_DUR       = 5'd4;
  localparam logic [FID_W-1:0] FID_MEAN      = 5'd5;
  localparam logic [FID_W-1:0] FID_MEAN_END  = 5'd10;
  localparam logic [FID_W-1:0] FID_DEV       = 5'd11;
  localparam logic [FID_W-1:0] FID_DEV_END   = 5'd16;
  localparam logic [FID_W-1:0] FID_ENERGY    = 5'd17;
  localparam logic [FID_W-1:0] FID_ENERGY_END = 5'd22;
  localparam logic [FID_W-1:0] FID_MJERK     = 5'd23;
  localparam logic [FID_W-1:0] FID_PJERK     = 5'd24;
  localparam logic [FID_W-1:0] FID_PACC      = 5'd25;
  localparam logic [FID_W-1:0] FID_PGYRO     = 5'd26;
  localparam logic [FID_W-1:0] FID_LAST      = 5'd26;

  typedef enum logic [1:0] {
    DIV_JERK,
    DIV_MEAN,
    DIV_DEV,
    DIV_MJERK
  } div_op_e;

  typedef struct packed {
    logic             write;
    logic             clear;
    logic             snap_begin;
    logic             empty_emit;
    logic             sample;
    logic             div_start;
    div_op_e          div_op;
    logic             jerk_acc;
    logic             dev_prep;
    logic             sqrt_start;
    logic             emit;
    logic [FID_W-1:0] fid;
  } ctrl_cmd_t;

  typedef struct packed {
    logic snap_empty;
    logic jerk_cond;
    logic walk_last;
    logic walk_done;
    logic jcnt_zero;
    logic div_busy;
    logic sqrt_busy;
  } dp_status_t;

  function automatic logic is_mean(input logic [FID_W-1:0] fid);
    return (fid >= FID_MEAN) && (fid <= FID_MEAN_END);
  endfunction

  function automatic logic is_dev(input logic [FID_W-1:0] fid);
    return (fid >= FID_DEV) && (fid <= FID_DEV_END);
  endfunction

  // Axis that a mean, deviation or energy feature refers to.
  function automatic logic [AXIS_IDX_W-1:0] axis_of(input logic [FID_W-1:0] fid);
    logic [FID_W-1:0] a;
    a = '0;
    if (fid >= FID_ENERGY) begin
      a = fid - FID_ENERGY;
    end else if (fid >= FID_DEV) begin
      a = fid - FID_DEV;
    end else if (fid >= FID_MEAN) begin
      a = fid - FID_MEAN;
    end
    return a[AXIS_IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: design/windowed_motion_feature_extractor.sv
// ----------------------------------------------------------------------------
// Windowed motion-feature extractor
// Keeps a ring of recent motion samples and reports window statistics.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low; mode_i selects
// add sample, snapshot or clear. Adding and clearing never
// raise busy, so a new request can follow in the next cycle.
// A snapshot of an empty or disabled window returns one result (feature 0,
// value 0, marked last) in the cycle after the request. Otherwise busy stays
// high while the window is walked oldest first and the 27 features go out in
// order, each on result_valid_o for a single cycle, the last one marked.
// The walk reads each stored sample in turn and sends the jerk of each
// pair whose stamps rise through the divider. Each mean then takes a
// divide, each deviation a divide and a square root, and the mean jerk a
// divide unless no pair has rising stamps; every other feature needs none.
// The arithmetic uses the shared one-bit-per-cycle divider and the
// square-root unit.
// Results cannot be held off by the receiver; it must take each on arrival.
// Reset empties the window and sets the enable register to one. The enable
// register is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module windowed_motion_feature_extractor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [wmfe_pkg::MODE_W-1:0]         mode_i,
  input  logic                                sample_valid_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_x_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_y_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_z_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_x_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_y_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_z_i,
  input  logic [wmfe_pkg::MAG_W-1:0]          accel_magnitude_i,
  input  logic [wmfe_pkg::MAG_W-1:0]          gyro_magnitude_i,
  input  logic [wmfe_pkg::TIME_W-1:0]         timestamp_ms_i,
  // Result channel.
  output logic                                result_valid_o,
  output logic [wmfe_pkg::FID_W-1:0]          feature_id_o,
  output logic signed [wmfe_pkg::VAL_W-1:0]   feature_value_o,
  output logic                                last_feature_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // The single register is the enable bit. Bit 2 of the address selects the
  // register index, so an access at byte address 4 falls outside the map.
  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == wmfe_pkg::REG_ENABLE) begin
      enable_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wmfe_pkg::REG_ENABLE) ? {31'd0, enable_q} : '0;

  // The controller sequences the walk and the features; the datapath holds
  // the ring, the accumulators and the arithmetic units.
  wmfe_pkg::ctrl_cmd_t  cmd;
  wmfe_pkg::dp_status_t status;

  wmfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  wmfe_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .enable_i          (enable_q),
    .sample_valid_i    (sample_valid_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .gyro_x_i          (gyro_x_i),
    .gyro_y_i          (gyro_y_i),
    .gyro_z_i          (gyro_z_i),
    .accel_magnitude_i (accel_magnitude_i),
    .gyro_magnitude_i  (gyro_magnitude_i),
    .timestamp_ms_i    (timestamp_ms_i),
    .result_valid_o    (result_valid_o),
    .feature_id_o      (feature_id_o),
    .feature_value_o   (feature_value_o),
    .last_feature_o    (last_feature_o)
  );

endmodule

FILE: design/wmfe_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module wmfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/wmfe_ctrl.sv
// ----------------------------------------------------------------------------
// Windowed motion-feature extractor controller
// Sequences the window walk and the per-feature computations.
// ----------------------------------------------------------------------------
module wmfe_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wmfe_pkg::MODE_W-1:0]   mode_i,
  input  wmfe_pkg::dp_status_t          status_i,
  output wmfe_pkg::ctrl_cmd_t           cmd_o,
  output logic                          busy_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_READ      = 4'd1;
  localparam logic [3:0] S_SAMPLE    = 4'd2;
  localparam logic [3:0] S_JDIV      = 4'd3;
  localparam logic [3:0] S_FEAT      = 4'd4;
  localparam logic [3:0] S_DEV       = 4'd5;
  localparam logic [3:0] S_DIV_WAIT  = 4'd6;
  localparam logic [3:0] S_SQRT_WAIT = 4'd7;
  localparam logic [3:0] S_EMIT      = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [wmfe_pkg::FID_W-1:0]   fid_q, fid_d;

  always_comb begin
    cmd_o     = '0;
    cmd_o.fid = fid_q;
    state_d   = state_q;
    fid_d     = fid_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            wmfe_pkg::MODE_ADD:   cmd_o.write = 1'b1;
            wmfe_pkg::MODE_CLEAR: cmd_o.clear = 1'b1;
            wmfe_pkg::MODE_SNAP: begin
              if (status_i.snap_empty) begin
                cmd_o.empty_emit = 1'b1;
              end else begin
                cmd_o.snap_begin = 1'b1;
                state_d          = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: state_d = S_SAMPLE;
      S_SAMPLE: begin
        cmd_o.sample = 1'b1;
        if (status_i.jerk_cond) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = wmfe_pkg::DIV_JERK;
          state_d         = S_JDIV;
        end else if (status_i.walk_last) begin
          fid_d   = wmfe_pkg::FID_AVAIL;
          state_d = S_FEAT;
        end else begin
          state_d = S_READ;
        end
      end
      S_JDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.jerk_acc = 1'b1;
          if (status_i.walk_done) begin
            fid_d   = wmfe_pkg::FID_AVAIL;
            state_d = S_FEAT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_FEAT: begin
        if (wmfe_pkg::is_mean(fid_q)) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = wmfe_pkg::DIV_MEAN;
          state_d         = S_DIV_WAIT;
        end else if (wmfe_pkg::is_dev(fid_q)) begin
          cmd_o.dev_prep = 1'b1;
          state_d        = S_DEV;
        end else if (fid_q == wmfe_pkg::FID_MJERK && !status_i.jcnt_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = wmfe_pkg::DIV_MJERK;
          state_d         = S_DIV_WAIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DEV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = wmfe_pkg::DIV_DEV;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          if (wmfe_pkg::is_dev(fid_q)) begin
            cmd_o.sqrt_start = 1'b1;
            state_d          = S_SQRT_WAIT;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_SQRT_WAIT: begin
        if (!status_i.sqrt_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (fid_q == wmfe_pkg::FID_LAST) begin
          state_d = S_IDLE;
        end else begin
          fid_d   = fid_q + 1'b1;
          state_d = S_FEAT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fid_q   <= '0;
    end else begin
      state_q <= state_d;
      fid_q   <= fid_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: design/wmfe_datapath.sv
// ----------------------------------------------------------------------------
// Windowed motion-feature extractor datapath
// Sample ring, walk accumulators, shared restoring divider, square-root unit
// and the registered result stage.
// ----------------------------------------------------------------------------
module wmfe_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wmfe_pkg::ctrl_cmd_t                 cmd_i,
  output wmfe_pkg::dp_status_t                status_o,
  input  logic                                enable_i,
  input  logic                                sample_valid_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_x_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_y_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  accel_z_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_x_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_y_i,
  input  logic signed [wmfe_pkg::AXIS_W-1:0]  gyro_z_i,
  input  logic [wmfe_pkg::MAG_W-1:0]          accel_magnitude_i,
  input  logic [wmfe_pkg::MAG_W-1:0]          gyro_magnitude_i,
  input  logic [wmfe_pkg::TIME_W-1:0]         timestamp_ms_i,
  output logic                                result_valid_o,
  output logic [wmfe_pkg::FID_W-1:0]          feature_id_o,
  output logic signed [wmfe_pkg::VAL_W-1:0]   feature_value_o,
  output logic                                last_feature_o
);

  localparam int unsigned AW   = wmfe_pkg::AXIS_W;
  localparam int unsigned MW   = wmfe_pkg::MAG_W;
  localparam int unsigned TW   = wmfe_pkg::TIME_W;
  localparam int unsigned SW   = wmfe_pkg::SUM_W;
  localparam int unsigned QW   = wmfe_pkg::SQ_W;
  localparam int unsigned DW   = wmfe_pkg::DVD_W;
  localparam int unsigned VW   = wmfe_pkg::VAL_W;
  localparam int unsigned RW   = wmfe_pkg::ROOT_W;
  localparam int unsigned NAX  = wmfe_pkg::NUM_AXES;

  // --------------------------------------------------------------------------
  // Ring write side
  // --------------------------------------------------------------------------
  logic [wmfe_pkg::PTR_W-1:0]   wp_q, idx_q;
  logic [wmfe_pkg::CNT_W-1:0]   fill_q, off_q;
  logic                         wr_en;
  logic [wmfe_pkg::ENTRY_W-1:0] wdata, rdata;

  assign wr_en = cmd_i.write && enable_i && sample_valid_i;
  assign wdata = {timestamp_ms_i, gyro_magnitude_i, accel_magnitude_i,
                  gyro_z_i, gyro_y_i, gyro_x_i, accel_z_i, accel_y_i, accel_x_i};

  wmfe_ram #(
    .WIDTH (wmfe_pkg::ENTRY_W),
    .DEPTH (wmfe_pkg::WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // --------------------------------------------------------------------------
  // Fields of the entry being walked
  // --------------------------------------------------------------------------
  logic signed [AW-1:0]   axv [NAX];
  logic signed [2*AW-1:0] axsq [NAX];
  logic [MW-1:0]          r_amag, r_gmag, dm;
  logic [TW-1:0]          r_time, dt;
  logic [wmfe_pkg::JNUM_W-1:0] jnum;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      axv[i]  = rdata[i*AW +: AW];
      axsq[i] = axv[i] * axv[i];
    end
  end

  assign r_amag = rdata[wmfe_pkg::AMAG_LO +: MW];
  assign r_gmag = rdata[wmfe_pkg::GMAG_LO +: MW];
  assign r_time = rdata[wmfe_pkg::TIME_LO +: TW];

  // Walk accumulators.
  logic signed [SW-1:0]         sum_q [NAX];
  logic [QW-1:0]                sq_q  [NAX];
  logic [MW-1:0]                pa_q, pg_q, prev_m_q;
  logic [TW-1:0]                t0_q, t1_q, prev_t_q;
  logic [wmfe_pkg::JSUM_W-1:0]  jsum_q;
  logic [wmfe_pkg::JNUM_W-1:0]  jpeak_q;
  logic [wmfe_pkg::CNT_W-1:0]   jcnt_q;

  assign dm   = (r_amag > prev_m_q) ? r_amag - prev_m_q : prev_m_q - r_amag;
  assign dt   = r_time - prev_t_q;
  assign jnum = wmfe_pkg::JNUM_W'(dm) * wmfe_pkg::JNUM_W'(wmfe_pkg::JERK_SCALE);

  // --------------------------------------------------------------------------
  // Selected axis for mean, deviation and energy features
  // --------------------------------------------------------------------------
  logic [wmfe_pkg::AXIS_IDX_W-1:0] axis;
  logic signed [SW-1:0]            sum_sel;
  logic [SW-1:0]                   abs_sel;
  logic [QW-1:0]                   sq_sel;

  assign axis    = wmfe_pkg::axis_of(cmd_i.fid);
  assign sum_sel = sum_q[axis];
  assign sq_sel  = sq_q[axis];
  assign abs_sel = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);

  // Deviation operands, one product per register.
  logic [wmfe_pkg::NSQ_W-1:0]   nsq_q;
  logic [wmfe_pkg::S2_W-1:0]    s2_q;
  logic [wmfe_pkg::DEV_D_W-1:0] dev_d;

  assign dev_d = (wmfe_pkg::DEV_D_W'(nsq_q) > wmfe_pkg::DEV_D_W'(s2_q))
               ? wmfe_pkg::DEV_D_W'(nsq_q) - wmfe_pkg::DEV_D_W'(s2_q) : '0;

  // --------------------------------------------------------------------------
  // Shared restoring divider, one quotient bit per cycle. The dividend is
  // left-aligned so that only as many steps run as the operand has bits.
  // --------------------------------------------------------------------------
  logic [DW-1:0]                dvd_q, quo_q, dvd_start;
  logic [wmfe_pkg::DVS_W-1:0]   dvs_q, rem_q, dvs_start;
  logic [wmfe_pkg::IT_W-1:0]    dcnt_q, it_start;
  logic                         div_busy_q;
  logic [wmfe_pkg::DVS_W:0]     rem_sh, rem_sub;
  logic                         rem_ge;

  always_comb begin
    dvd_start = '0;
    dvs_start = '0;
    it_start  = '0;
    case (cmd_i.div_op)
      wmfe_pkg::DIV_JERK: begin
        dvd_start = DW'(jnum) << (DW - wmfe_pkg::JNUM_W);
        dvs_start = dt;
        it_start  = wmfe_pkg::IT_W'(wmfe_pkg::JNUM_W);
      end
      wmfe_pkg::DIV_MEAN: begin
        dvd_start = DW'({abs_sel, {wmfe_pkg::FRAC_W{1'b0}}}) << (DW - wmfe_pkg::MEAN_DVD_W);
        dvs_start = wmfe_pkg::DVS_W'(fill_q);
        it_start  = wmfe_pkg::IT_W'(wmfe_pkg::MEAN_DVD_W);
      end
      wmfe_pkg::DIV_DEV: begin
        dvd_start = DW'({dev_d, {wmfe_pkg::DEV_SHIFT{1'b0}}}) << (DW - wmfe_pkg::DEV_DVD_W);
        dvs_start = wmfe_pkg::DVS_W'(wmfe_pkg::NN_W'(fill_q) * wmfe_pkg::NN_W'(fill_q));
        it_start  = wmfe_pkg::IT_W'(wmfe_pkg::DEV_DVD_W);
      end
      default: begin
        dvd_start = DW'(jsum_q) << (DW - wmfe_pkg::JSUM_W);
        dvs_start = wmfe_pkg::DVS_W'(jcnt_q);
        it_start  = wmfe_pkg::IT_W'(wmfe_pkg::JSUM_W);
      end
    endcase
  end

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // --------------------------------------------------------------------------
  // Square-root unit, one root bit per cycle.
  // --------------------------------------------------------------------------
  logic [wmfe_pkg::SQI_W-1:0] sqi_q;
  logic [RW+1:0]              srem_q;
  logic [RW-1:0]              root_q;
  logic [wmfe_pkg::RIT_W-1:0] scnt_q;
  logic                       sqrt_busy_q;
  logic [RW+3:0]              srem_x, strial;
  logic                       s_ge;

  assign srem_x = {srem_q, sqi_q[wmfe_pkg::SQI_W-1 -: 2]};
  assign strial = {2'b00, root_q, 2'b01};
  assign s_ge   = srem_x >= strial;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      div_busy_q  <= 1'b0;
      sqrt_busy_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        wp_q   <= '0;
        fill_q <= '0;
      end else if (wr_en) begin
        wp_q <= wmfe_pkg::next_ptr(wp_q);
        if (fill_q != wmfe_pkg::CNT_W'(wmfe_pkg::WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q && dcnt_q == wmfe_pkg::IT_W'(1)) begin
        div_busy_q <= 1'b0;
      end
      if (cmd_i.sqrt_start) begin
        sqrt_busy_q <= 1'b1;
      end else if (sqrt_busy_q && scnt_q == wmfe_pkg::RIT_W'(1)) begin
        sqrt_busy_q <= 1'b0;
      end
      valid_q <= cmd_i.emit || cmd_i.empty_emit;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.snap_begin) begin
      idx_q   <= (fill_q == wmfe_pkg::CNT_W'(wmfe_pkg::WINDOW)) ? wp_q : '0;
      off_q   <= '0;
      pa_q    <= '0;
      pg_q    <= '0;
      jsum_q  <= '0;
      jpeak_q <= '0;
      jcnt_q  <= '0;
      for (int i = 0; i < NAX; i++) begin
        sum_q[i] <= '0;
        sq_q[i]  <= '0;
      end
    end
    if (cmd_i.sample) begin
      for (int i = 0; i < NAX; i++) begin
        sum_q[i] <= sum_q[i] + SW'(axv[i]);
        sq_q[i]  <= sq_q[i] + QW'(unsigned'(axsq[i]));
      end
      if (r_amag > pa_q) pa_q <= r_amag;
      if (r_gmag > pg_q) pg_q <= r_gmag;
      if (off_q == '0) t0_q <= r_time;
      t1_q     <= r_time;
      prev_t_q <= r_time;
      prev_m_q <= r_amag;
      off_q    <= off_q + 1'b1;
      idx_q    <= wmfe_pkg::next_ptr(idx_q);
    end
    if (cmd_i.jerk_acc) begin
      jsum_q <= jsum_q + wmfe_pkg::JSUM_W'(quo_q[wmfe_pkg::JNUM_W-1:0]);
      if (quo_q[wmfe_pkg::JNUM_W-1:0] > jpeak_q) jpeak_q <= quo_q[wmfe_pkg::JNUM_W-1:0];
      jcnt_q <= jcnt_q + 1'b1;
    end
    if (cmd_i.dev_prep) begin
      nsq_q <= wmfe_pkg::NSQ_W'(fill_q) * wmfe_pkg::NSQ_W'(sq_sel);
      s2_q  <= wmfe_pkg::S2_W'(abs_sel) * wmfe_pkg::S2_W'(abs_sel);
    end

    if (cmd_i.div_start) begin
      dvd_q  <= dvd_start;
      dvs_q  <= dvs_start;
      dcnt_q <= it_start;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (div_busy_q) begin
      rem_q  <= rem_ge ? rem_sub[wmfe_pkg::DVS_W-1:0] : rem_sh[wmfe_pkg::DVS_W-1:0];
      quo_q  <= {quo_q[DW-2:0], rem_ge};
      dvd_q  <= dvd_q << 1;
      dcnt_q <= dcnt_q - 1'b1;
    end

    if (cmd_i.sqrt_start) begin
      sqi_q  <= wmfe_pkg::SQI_W'(quo_q);
      srem_q <= '0;
      root_q <= '0;
      scnt_q <= wmfe_pkg::RIT_W'(RW);
    end else if (sqrt_busy_q) begin
      srem_q <= s_ge ? (RW+2)'(srem_x - strial) : (RW+2)'(srem_x);
      root_q <= {root_q[RW-2:0], s_ge};
      sqi_q  <= sqi_q << 2;
      scnt_q <= scnt_q - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result selection and output register
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] value;
  logic signed [VW-1:0] mean_mag;

  assign mean_mag = VW'(quo_q[wmfe_pkg::MEAN_DVD_W-1:0]);

  always_comb begin
    value = '0;
    case (cmd_i.fid) inside
      wmfe_pkg::FID_AVAIL: value = VW'(1);
      wmfe_pkg::FID_COUNT: value = VW'(fill_q);
      wmfe_pkg::FID_START: value = VW'(t0_q);
      wmfe_pkg::FID_END:   value = VW'(t1_q);
      wmfe_pkg::FID_DUR:   value = (t1_q >= t0_q) ? VW'(t1_q - t0_q) : '0;
      [wmfe_pkg::FID_MEAN:wmfe_pkg::FID_MEAN_END]:
        value = sum_sel[SW-1] ? -mean_mag : mean_mag;
      [wmfe_pkg::FID_DEV:wmfe_pkg::FID_DEV_END]:
        value = VW'(root_q);
      [wmfe_pkg::FID_ENERGY:wmfe_pkg::FID_ENERGY_END]:
        value = VW'(sq_sel);
      wmfe_pkg::FID_MJERK:
        value = (jcnt_q == '0) ? '0 : VW'(quo_q[wmfe_pkg::JNUM_W-1:0]);
      wmfe_pkg::FID_PJERK: value = VW'(jpeak_q);
      wmfe_pkg::FID_PACC:  value = VW'(pa_q);
      wmfe_pkg::FID_PGYRO: value = VW'(pg_q);
      default:             value = '0;
    endcase
  end

  logic [wmfe_pkg::FID_W-1:0] id_q;
  logic signed [VW-1:0]       val_q;
  logic                       last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.empty_emit) begin
      id_q   <= wmfe_pkg::FID_AVAIL;
      val_q  <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.emit) begin
      id_q   <= cmd_i.fid;
      val_q  <= value;
      last_q <= (cmd_i.fid == wmfe_pkg::FID_LAST);
    end
  end

  assign result_valid_o  = valid_q;
  assign feature_id_o    = id_q;
  assign feature_value_o = val_q;
  assign last_feature_o  = last_q;

  // --------------------------------------------------------------------------
  // Status back to the controller
  // --------------------------------------------------------------------------
  assign status_o.snap_empty = !enable_i || (fill_q == '0);
  assign status_o.jerk_cond  = (off_q != '0) && (r_time > prev_t_q);
  assign status_o.walk_last  = (off_q + 1'b1 == fill_q);
  assign status_o.walk_done  = (off_q == fill_q);
  assign status_o.jcnt_zero  = (jcnt_q == '0);
  assign status_o.div_busy   = div_busy_q;
  assign status_o.sqrt_busy  = sqrt_busy_q;

endmodule

FILE: design/wmfe_checker.sv
// ----------------------------------------------------------------------------
// Windowed motion-feature extractor checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module wmfe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [wmfe_pkg::MODE_W-1:0]       mode_i,
  input logic                              result_valid_o,
  input logic [wmfe_pkg::FID_W-1:0]        feature_id_o,
  input logic                              last_feature_o
);

  // A result that is not the last of its snapshot leaves the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_feature_o |-> busy)
    else $error("non-final result while idle");

  // Adding a sample never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && mode_i == wmfe_pkg::MODE_ADD |=> !result_valid_o)
    else $error("result after an add request");

  // A snapshot request either answers at once or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && mode_i == wmfe_pkg::MODE_SNAP |=> result_valid_o || busy)
    else $error("snapshot request lost");

  // The final result is either the lone empty answer or the last feature.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_feature_o |->
      feature_id_o == wmfe_pkg::FID_AVAIL || feature_id_o == wmfe_pkg::FID_LAST)
    else $error("last mark on a wrong feature");

endmodule

bind windowed_motion_feature_extractor wmfe_checker u_wmfe_checker (.*);
